// ----- hw/rtl/blpm_pkg.sv -----
// shared types, constants and codes for the binary trie longest prefix match core
// no dependencies
package blpm_pkg;

  localparam int NODE_ENTRIES = 4096;
  localparam int NODE_AW      = $clog2(NODE_ENTRIES);
  localparam int ADDRESS_BITS = 128;
  localparam int ADDR_W       = 128;
  localparam int DEPTH_W      = 8;
  localparam int NODE_CNT_W   = 13;
  localparam int NET_CNT_W    = 17;
  localparam int NET_W        = 16;
  localparam int CFG_W        = 17;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic CFG_NODE_COUNT    = 1'b0;
  localparam logic CFG_NETWORK_COUNT = 1'b1;

  localparam logic [1:0] ST_FOUND       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [1:0] ST_BAD_NODE    = 2'd2;
  localparam logic [1:0] ST_BAD_NETWORK = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [11:0] node_slot;
    logic [11:0] zero_child;
    logic [11:0] one_child;
    logic        has_network;
    logic [15:0] network_number;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] match_net;
    logic [7:0]  prefix_length;
  } out_t;

  typedef struct packed {
    logic [NODE_AW-1:0] zero_child;
    logic [NODE_AW-1:0] one_child;
    logic               has_network;
    logic [NET_W-1:0]   network_number;
  } node_t;

  typedef struct packed {
    logic               kind;
    logic [NODE_AW-1:0] slot;
    node_t              node;
    logic [ADDR_W-1:0]  addr;
  } work_t;

endpackage

// ----- hw/rtl/blpm_front.sv -----
// front end: takes commands, classifies them and packs them for the work queue
// depends on blpm_pkg
module blpm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  blpm_pkg::in_t   item,
  input  logic            q_full,
  output logic            push,
  output blpm_pkg::work_t push_data
);
  import blpm_pkg::*;

  logic  fv;
  work_t fw;
  work_t fw_next;
  logic  accept;

  assign busy   = fv && q_full;
  assign accept = start && !busy;
  assign push   = fv && !q_full;
  assign push_data = fw;

  always_comb begin
    fw_next.kind                = (item.opcode == OP_LOOKUP) ? OP_LOOKUP : OP_LOAD;
    fw_next.slot                = item.node_slot[NODE_AW-1:0];
    fw_next.node.zero_child     = item.zero_child[NODE_AW-1:0];
    fw_next.node.one_child      = item.one_child[NODE_AW-1:0];
    fw_next.node.has_network    = item.has_network;
    fw_next.node.network_number = item.network_number;
    fw_next.addr                = {item.address_high, item.address_low};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fw <= fw_next;
    end
  end

endmodule

// ----- hw/rtl/blpm_queue.sv -----
// short work queue between the front end and the trie walker
// depends on blpm_pkg
module blpm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  blpm_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output blpm_pkg::work_t head
);
  import blpm_pkg::*;

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/blpm_back.sv -----
// back end: node table memory, config registers and the one-level-per-cycle trie walk
// depends on blpm_pkg
module blpm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [blpm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         empty,
  input  blpm_pkg::work_t              head,
  output logic                         pop,
  output logic                         done,
  output blpm_pkg::out_t               result
);
  import blpm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                  state;
  logic [NODE_CNT_W-1:0] node_count;
  logic [NET_CNT_W-1:0]  network_count;
  logic [ADDR_W-1:0]     addr;
  logic [DEPTH_W-1:0]    depth;
  logic                  found;
  logic [NET_W-1:0]      best_net;
  logic [DEPTH_W-1:0]    best_depth;

  node_t                 node_mem [NODE_ENTRIES];
  node_t                 rd_node;
  logic [NODE_AW-1:0]    rd_addr;

  logic [NODE_AW-1:0]    child;
  logic                  found_next;
  logic [NET_W-1:0]      best_net_next;
  logic [DEPTH_W-1:0]    best_depth_next;
  logic                  at_end;
  logic                  child_zero;
  logic                  bad_node;
  logic                  bad_net;

  assign pop = (state == ST_IDLE) && !empty;

  always_comb begin
    child           = addr[ADDR_W-1] ? rd_node.one_child : rd_node.zero_child;
    found_next      = found || rd_node.has_network;
    best_net_next   = rd_node.has_network ? rd_node.network_number : best_net;
    best_depth_next = rd_node.has_network ? depth : best_depth;
    at_end          = depth == DEPTH_W'(ADDRESS_BITS);
    child_zero      = child == '0;
    bad_node        = {1'b0, child} >= node_count;
    bad_net         = {1'b0, best_net_next} >= network_count;
    rd_addr         = (state == ST_WALK) ? child : '0;
  end

  // node table: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (pop && head.kind == OP_LOAD) begin
      node_mem[head.slot] <= head.node;
    end
    rd_node <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      node_count    <= NODE_CNT_W'(1);
      network_count <= '0;
    end else begin
      done <= (state == ST_WALK) && (at_end || child_zero || bad_node);
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT:    node_count    <= cfg_data[NODE_CNT_W-1:0];
          CFG_NETWORK_COUNT: network_count <= cfg_data[NET_CNT_W-1:0];
          default:           ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (pop && head.kind == OP_LOOKUP) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (at_end || child_zero || bad_node) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // walk datapath and result register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        addr       <= head.addr;
        depth      <= '0;
        found      <= 1'b0;
        best_net   <= '0;
        best_depth <= '0;
      end
      ST_WALK: begin
        addr       <= addr << 1;
        depth      <= depth + 1'b1;
        found      <= found_next;
        best_net   <= best_net_next;
        best_depth <= best_depth_next;
        if (!at_end && !child_zero && bad_node) begin
          result <= '{status: ST_BAD_NODE, match_net: '0, prefix_length: '0};
        end else if (!found_next) begin
          result <= '{status: ST_NOT_FOUND, match_net: '0, prefix_length: '0};
        end else if (bad_net) begin
          result <= '{status: ST_BAD_NETWORK, match_net: '0, prefix_length: '0};
        end else begin
          result <= '{status: ST_FOUND, match_net: best_net_next,
                      prefix_length: best_depth_next};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (depth <= DEPTH_W'(ADDRESS_BITS)))
    else $error("walk depth past address width");

  a_done_from_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WALK))
    else $error("result strobe without a walk");

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !pop)
    else $error("queue popped during a walk");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_FOUND) |->
      (result.match_net == '0 && result.prefix_length == '0))
    else $error("nonzero payload on a miss or error");
`endif

endmodule

// ----- hw/rtl/binary_trie_longest_prefix_match_core.sv -----
// top level of the binary trie longest prefix match core
// depends on blpm_pkg, blpm_front, blpm_queue, blpm_back
//
// channel  | ports                        | transfer
// ---------+------------------------------+-------------------------------
// command  | start, busy, item            | edge with start high, busy low
// result   | done, result                 | edge ending the done cycle
// config   | cfg_we, cfg_index, cfg_data  | edge with cfg_we high
//
// with an empty queue and an idle walker a load passes through the front register and a queue
// slot before it is written to the node table; a lookup reads 1 to 129 trie levels, each of which
// waits on one registered read of the node table memory.
// the walker takes no new item while it walks a lookup; queued items wait behind it.
// rst is synchronous: it empties the queue, stops any walk and restores the
// config registers; the node table is not cleared. busy rises only when the
// front register and the four-entry queue are both full. done cannot be stalled.
module binary_trie_longest_prefix_match_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  blpm_pkg::in_t              item,
  output logic                       done,
  output blpm_pkg::out_t             result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [blpm_pkg::CFG_W-1:0] cfg_data
);
  import blpm_pkg::*;

  logic  push;
  work_t push_data;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  work_t head;

  blpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  blpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  blpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- tb/tb_binary_trie_longest_prefix_match_core.sv -----
// self-checking testbench for binary_trie_longest_prefix_match_core
// keeps its own copy of the node table and walks it to predict every lookup result
// depends on blpm_pkg and the core rtl
`timescale 1ns / 1ps

module tb_binary_trie_longest_prefix_match_core;
  import blpm_pkg::*;

  localparam int NET_ENTRIES   = 1 << NET_W;
  localparam int ABIT_W        = $clog2(ADDR_W);
  localparam int ITEM_TARGET   = 1950;
  localparam int SETTLE_CYCLES = 64;
  localparam int PRINT_CAP     = 200;

  logic           clk = 1'b0;
  logic           rst;
  logic           start;
  logic           busy;
  in_t            item;
  logic           done;
  out_t           result;
  logic           cfg_we;
  logic           cfg_index;
  logic [CFG_W-1:0] cfg_data;

  binary_trie_longest_prefix_match_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  node_t trie_mem [NODE_ENTRIES];
  bit    node_written [NODE_ENTRIES];
  int    node_count_cfg = 1;
  int    network_count_cfg = 0;
  out_t  pending_results [$];
  out_t  oldest_result;

  int errors = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int lookups_sent = 0;
  int results_seen = 0;
  int longest_prefix = 0;
  int status_count [4] = '{0, 0, 0, 0};
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int node_limit();
    return (node_count_cfg < NODE_ENTRIES) ? node_count_cfg : NODE_ENTRIES;
  endfunction

  function automatic int net_limit();
    return (network_count_cfg < NET_ENTRIES) ? network_count_cfg : NET_ENTRIES;
  endfunction

  // longest prefix walk over the local node table; missing names the first unwritten node read
  function automatic void walk_trie(input logic [ADDR_W-1:0] addr, output out_t res,
                                    output int missing);
    int    node;
    int    depth;
    int    child;
    int    best_depth;
    bit    found;
    logic [NET_W-1:0] best_net;
    node_t nd;
    node = 0;
    depth = 0;
    found = 1'b0;
    best_net = '0;
    best_depth = 0;
    missing = -1;
    res = '0;
    while (1) begin
      if (!node_written[NODE_AW'(node)]) begin
        missing = node;
        return;
      end
      nd = trie_mem[NODE_AW'(node)];
      if (nd.has_network) begin
        found = 1'b1;
        best_net = nd.network_number;
        best_depth = depth;
      end
      if (depth >= ADDRESS_BITS) break;
      child = addr[ABIT_W'(ADDR_W-1-depth)] ? nd.one_child : nd.zero_child;
      if (child == 0) break;
      if (child >= node_limit()) begin
        res.status = ST_BAD_NODE;
        return;
      end
      node = child;
      depth++;
    end
    if (!found) begin
      res.status = ST_NOT_FOUND;
    end else if (best_net >= net_limit()) begin
      res.status = ST_BAD_NETWORK;
    end else begin
      res.status = ST_FOUND;
      res.match_net = best_net;
      res.prefix_length = DEPTH_W'(best_depth);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.opcode = 1'($urandom_range(0, 1));
    it.node_slot = 12'($urandom);
    it.zero_child = 12'($urandom);
    it.one_child = 12'($urandom);
    it.has_network = 1'($urandom_range(0, 1));
    it.network_number = 16'($urandom);
    it.address_high = {$urandom, $urandom};
    it.address_low = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [11:0] pick_child();
    logic [11:0] v;
    int lim;
    lim = node_limit();
    v = 12'($urandom);
    case ($urandom_range(0, 3))
      0, 1: v = '0;
      2: if (lim > 1) v = 12'($urandom_range(1, lim - 1));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [NET_W-1:0] pick_net();
    logic [NET_W-1:0] v;
    v = NET_W'($urandom);
    if (net_limit() > 0 && $urandom_range(0, 3) != 0)
      v = NET_W'($urandom_range(0, net_limit() - 1));
    return v;
  endfunction

  // one command transfer, then the local model is updated
  task automatic send_item(input in_t it);
    out_t  res;
    int    missing;
    node_t nd;
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    items_sent++;
    if (it.opcode == OP_LOAD) begin
      nd.zero_child = it.zero_child;
      nd.one_child = it.one_child;
      nd.has_network = it.has_network;
      nd.network_number = it.network_number;
      trie_mem[it.node_slot] = nd;
      node_written[it.node_slot] = 1'b1;
      loads_sent++;
    end else begin
      walk_trie({it.address_high, it.address_low}, res, missing);
      pending_results.push_back(res);
      status_count[res.status]++;
      if (res.status == ST_FOUND && res.prefix_length > longest_prefix)
        longest_prefix = int'(res.prefix_length);
      lookups_sent++;
    end
  endtask

  task automatic load_node(input int slot, input int zc, input int oc, input bit hn,
                           input int nn);
    in_t it;
    it = rand_item();
    it.opcode = OP_LOAD;
    it.node_slot = 12'(slot);
    it.zero_child = 12'(zc);
    it.one_child = 12'(oc);
    it.has_network = hn;
    it.network_number = NET_W'(nn);
    send_item(it);
  endtask

  // nodes the walk would read but that were never loaded are filled first
  task automatic lookup_addr(input logic [ADDR_W-1:0] addr);
    in_t  it;
    out_t res;
    int   missing;
    walk_trie(addr, res, missing);
    while (missing >= 0) begin
      load_node(missing, pick_child(), pick_child(), 1'($urandom_range(0, 1)), pick_net());
      walk_trie(addr, res, missing);
    end
    it = rand_item();
    it.opcode = OP_LOOKUP;
    it.address_high = addr[ADDR_W-1:64];
    it.address_low = addr[63:0];
    send_item(it);
  endtask

  task automatic write_reg(input logic idx, input int val);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_NODE_COUNT) node_count_cfg = val & 'h1FFF;
    else network_count_cfg = val & 'h1FFFF;
  endtask

  task automatic set_counts(input int nodes, input int nets);
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_NETWORK_COUNT, nets);
  endtask

  // chain of nodes from the root along addr; loop_end makes the last node its own child
  task automatic build_path(input logic [ADDR_W-1:0] addr, input int len, input bit loop_end);
    int cur;
    int nxt;
    int other;
    int d;
    int lim;
    lim = node_limit();
    cur = 0;
    for (d = 0; d <= len; d++) begin
      if (d == len || lim < 2) begin
        nxt = loop_end ? cur : pick_child();
        other = loop_end ? cur : pick_child();
      end else begin
        nxt = $urandom_range(1, lim - 1);
        other = pick_child();
      end
      if (addr[ABIT_W'(ADDR_W-1-d)])
        load_node(cur, other, nxt, $urandom_range(0, 2) == 0, pick_net());
      else load_node(cur, nxt, other, $urandom_range(0, 2) == 0, pick_net());
      if (d == len || lim < 2) break;
      cur = nxt;
    end
  endtask

  task automatic test_reset_config();
    load_node(0, 0, 0, 1'b1, 0);
    lookup_addr('0);
    load_node(0, 3, 3, 1'b0, 0);
    lookup_addr(rand_addr());
    write_reg(CFG_NODE_COUNT, 0);
    load_node(0, 0, 0, 1'b0, 0);
    lookup_addr(rand_addr());
    load_node(0, 1, 1, 1'b1, 2);
    lookup_addr(rand_addr());
  endtask

  task automatic test_walk_cases();
    set_counts(NODE_ENTRIES, NET_ENTRIES);
    load_node(0, 1, 2, 1'b1, 7);
    load_node(1, 1, 0, 1'b1, 16'hFFFF);
    load_node(2, 0, 4095, 1'b0, 0);
    load_node(4095, 4095, 4095, 1'b1, 16'hABCD);
    lookup_addr('0);
    lookup_addr('1);
    lookup_addr({64'h8000_0000_0000_0000, 64'h0});
    lookup_addr({64'h4000_0000_0000_0000, 64'h0});
    lookup_addr({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
  endtask

  task automatic test_count_limits();
    // deepest network out of range, no fallback to the root network
    write_reg(CFG_NETWORK_COUNT, 100);
    lookup_addr('0);
    // bad child below a node that carries a network
    write_reg(CFG_NODE_COUNT, 100);
    lookup_addr('1);
    set_counts(8191, 131071);
    lookup_addr('1);
    lookup_addr('0);
    write_reg(CFG_NETWORK_COUNT, 65535);
    lookup_addr('0);
    lookup_addr('1);
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int len;
    int k;
    logic [ADDR_W-1:0] addr;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: set_counts(NODE_ENTRIES, NET_ENTRIES);
        1: set_counts(1, 0);
        2: set_counts(8191, 131071);
        3: set_counts(16, 12);
        4: set_counts(2, NET_ENTRIES);
        default: set_counts($urandom_range(1, NODE_ENTRIES), $urandom_range(0, NET_ENTRIES));
      endcase
      phase_end = items_sent + 300;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        k = $urandom_range(0, 9);
        if (k < 5) begin
          addr = rand_addr();
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 127) : $urandom_range(0, 12);
          build_path(addr, len, $urandom_range(0, 5) == 0);
          lookup_addr(addr);
          if ($urandom_range(0, 1))
            lookup_addr(addr ^ ({{(ADDR_W-1){1'b0}}, 1'b1} << (ADDR_W - 1 - $urandom_range(0, len))));
          if ($urandom_range(0, 2) == 0) lookup_addr(rand_addr());
        end else if (k < 8) begin
          load_node($urandom_range(0, NODE_ENTRIES - 1), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
        end else begin
          lookup_addr(rand_addr());
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no lookup pending, status %0d", result.status));
      end else begin
        oldest_result = pending_results.pop_front();
        results_seen++;
        if (result.status !== oldest_result.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, oldest_result.status));
        if (result.match_net !== oldest_result.match_net)
          report_mismatch($sformatf("match_net %0d, expected %0d",
                                    result.match_net, oldest_result.match_net));
        if (result.prefix_length !== oldest_result.prefix_length)
          report_mismatch($sformatf("prefix_length %0d, expected %0d",
                                    result.prefix_length, oldest_result.prefix_length));
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_walk_cases();
    test_count_limits();
    test_random_traffic();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d node loads and %0d lookups, %0d results compared, deepest prefix %0d",
             loads_sent, lookups_sent, results_seen, longest_prefix);
    $display("found %0d, not found %0d, bad node %0d, bad network %0d, mismatches %0d",
             status_count[ST_FOUND], status_count[ST_NOT_FOUND], status_count[ST_BAD_NODE],
             status_count[ST_BAD_NETWORK], errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d lookup results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
